### design/cbp_pkg.sv
`default_nettype none

package cbp_pkg;

    typedef logic [1:0] t_ctr;

    localparam t_ctr CTR_RESET = 2'd3;

    // hysteresis update: a taken branch from one or two jumps to three, from
    // zero it only climbs to one; a not-taken branch drops three to two and
    // everything below three to zero
    function automatic t_ctr next_counter(input t_ctr ctr, input logic taken);
        t_ctr nxt;
        unique case (ctr)
            2'd3: nxt = taken ? 2'd3 : 2'd2;
            2'd2: nxt = taken ? 2'd3 : 2'd0;
            2'd1: nxt = taken ? 2'd3 : 2'd0;
            2'd0: nxt = taken ? 2'd1 : 2'd0;
            default: nxt = CTR_RESET;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

### design/correlating_branch_predictor.sv
`default_nettype none

// Correlating branch predictor with a global history register. Each input
// beat is one resolved branch; the low INDEX_BITS of the PC joined with the
// HISTORY_BITS history select a two-bit counter, whose value before the
// update gives the prediction on the output beat. One branch per cycle is
// sustained while the output is not stalled: the counter table is a single
// registered-read memory, and the read-modify-write of back-to-back branches
// to the same entry is covered by forwarding the last written counter.
// o_valid for a result rises once it moves from the read stage (r_s1) into
// the output register, which waits while a held result is stalled. After
// reset all 2**(INDEX_BITS+HISTORY_BITS) entries (4096 at the defaults) are
// cleared to strongly taken, one entry a cycle; o_ready stays low meanwhile.
module correlating_branch_predictor
    import cbp_pkg::*;
#(
    parameter int INDEX_BITS   = 10,
    parameter int HISTORY_BITS = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_branch_pc,
    input  wire logic        i_branch_taken,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_predict_taken
);

    localparam int TABLE_BITS = INDEX_BITS + HISTORY_BITS;
    localparam int DEPTH      = 1 << TABLE_BITS;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    t_state                  r_state, n_state;
    logic [TABLE_BITS-1:0]   r_clr_addr;
    logic [HISTORY_BITS-1:0] r_hist;
    logic [HISTORY_BITS:0]   hist_shift;

    logic                    r_s1_valid;
    logic [TABLE_BITS-1:0]   r_s1_addr;
    logic                    r_s1_taken;
    t_ctr                    r_rd_data;

    logic                    r_lw_valid;
    logic [TABLE_BITS-1:0]   r_lw_addr;
    t_ctr                    r_lw_data;

    logic                    r_out_valid;
    logic                    r_out_pred;

    t_ctr                    r_table [DEPTH];

    logic                    in_acc;
    logic                    s1_adv;
    logic                    clearing;
    logic [TABLE_BITS-1:0]   rd_addr;
    t_ctr                    s1_ctr;
    t_ctr                    s1_next;
    logic                    mem_we;
    logic [TABLE_BITS-1:0]   mem_waddr;
    t_ctr                    mem_wdata;

    assign clearing   = (r_state == ST_CLEAR);
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready    = (r_state == ST_RUN) && (!r_s1_valid || s1_adv);
    assign in_acc     = i_valid && o_ready;
    assign rd_addr    = {i_branch_pc[INDEX_BITS-1:0], r_hist};
    assign hist_shift = {r_hist, i_branch_taken};

    // forward the counter written at the edge that issued this read
    assign s1_ctr  = (r_lw_valid && (r_lw_addr == r_s1_addr)) ? r_lw_data : r_rd_data;
    assign s1_next = next_counter(s1_ctr, r_s1_taken);

    assign mem_we    = clearing || s1_adv;
    assign mem_waddr = clearing ? r_clr_addr : r_s1_addr;
    assign mem_wdata = clearing ? CTR_RESET : s1_next;

    assign o_valid         = r_out_valid;
    assign o_predict_taken = r_out_pred;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (&r_clr_addr) n_state = ST_RUN;
            end
            ST_RUN: n_state = ST_RUN;
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_table[mem_waddr] <= mem_wdata;
        if (in_acc) r_rd_data <= r_table[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_hist      <= '1;
            r_s1_valid  <= 1'b0;
            r_lw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr_addr <= r_clr_addr + 1'b1;
            if (in_acc) r_hist <= hist_shift[HISTORY_BITS-1:0];
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) r_lw_valid <= 1'b1;
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr  <= rd_addr;
            r_s1_taken <= i_branch_taken;
        end
        if (s1_adv) begin
            r_lw_addr  <= r_s1_addr;
            r_lw_data  <= s1_next;
            r_out_pred <= s1_ctr[1];
        end
    end

endmodule

`default_nettype wire

### design/cbp_checker.sv
`default_nettype none

module cbp_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_predict_taken
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_predict_taken))
        else $error("result beat dropped or changed under stall");

    // a fresh result beat traces back to an accepted branch
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result beat without an accepted branch");

    // reset starts the table clearing pass, which blocks input
    a_reset_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("input taken right after reset");

endmodule

bind correlating_branch_predictor cbp_checker u_cbp_checker (.*);

`default_nettype wire
